// ===== rtl/atrs_pkg.sv =====
`timescale 1ns / 1ps
package atrs_pkg;

	localparam int MAX_STUDENTS = 32;
	localparam int MAX_COURSES  = 16;
	localparam int IDX_W        = $clog2(MAX_STUDENTS);
	localparam int CNT_W        = $clog2(MAX_COURSES);
	localparam int MEAN_W       = 16;
	localparam int SUM_W        = 12;
	localparam int FRAC_W       = 8;
	localparam int DVD_W        = SUM_W + FRAC_W;
	localparam int DIV_CNT_W    = $clog2(DVD_W);

	localparam logic [1:0] REG_COURSE_COUNT  = 2'd0;
	localparam logic [1:0] REG_STUDENT_COUNT = 2'd1;
	localparam logic [1:0] REG_SORT_METHOD   = 2'd2;

	localparam logic [1:0] METHOD_BUBBLE    = 2'd0;
	localparam logic [1:0] METHOD_SELECTION = 2'd1;
	localparam logic [1:0] METHOD_INSERTION = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [MEAN_W-1:0] mean;
	} entry_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DIV,
		ST_STORE,
		ST_SCAN_START,
		ST_SCAN,
		ST_DECIDE,
		ST_SH_RD,
		ST_SH_WR,
		ST_PLACE,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/average_then_rank_sorter.sv =====
`timescale 1ns / 1ps
// Grades are taken one per cycle while the block loads a student. After the
// last grade of a student the input is stalled while a 20-step restoring
// divider forms the mean, one bit per cycle, and the store state then writes
// it to the entry memory. After the last student the block ranks the batch
// in that single memory: for each rank position i it scans entries i..n-1,
// moves the winner into place (a read and a write per shifted entry for
// bubble and insertion order, two writes for selection) and transfers one
// result; loading resumes once the last result is registered at the output.
module average_then_rank_sorter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [5:0]                        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        grade,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [4:0]                        rank,
	output logic [4:0]                        student,
	output logic [atrs_pkg::MEAN_W-1:0]       mean,
	output logic                              last
);

	logic [4:0] course_count_q;
	logic [5:0] student_count_q;
	logic [1:0] sort_method_q;
	logic [4:0] cc_eff;
	logic [5:0] sn_eff;

	atrs_pkg::state_t state_q, state_d;

	logic [atrs_pkg::SUM_W-1:0]     grade_sum_q;
	logic [atrs_pkg::CNT_W-1:0]     grade_counter_q;
	logic [atrs_pkg::IDX_W-1:0]     student_counter_q;
	logic [atrs_pkg::DVD_W-1:0]     dvd_q;
	logic [4:0]                     rem_q;
	logic [atrs_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [5:0]                     n_q;
	logic [atrs_pkg::IDX_W-1:0]     i_q;
	logic [atrs_pkg::IDX_W-1:0]     k_q;
	logic [atrs_pkg::IDX_W-1:0]     best_addr_q;
	atrs_pkg::entry_t               entry_i_q, best_q, emit_q;

	atrs_pkg::entry_t               mem_q [atrs_pkg::MAX_STUDENTS];
	atrs_pkg::entry_t               rd_data_s1;
	logic [atrs_pkg::IDX_W-1:0]     rd_addr_s1;
	logic [atrs_pkg::IDX_W-1:0]     rd_addr;
	logic                           mem_we;
	logic [atrs_pkg::IDX_W-1:0]     mem_waddr;
	atrs_pkg::entry_t               mem_wdata;

	logic                           out_valid_q;
	logic [4:0]                     rank_q, student_q;
	logic [atrs_pkg::MEAN_W-1:0]    mean_q;
	logic                           last_q;

	logic                           in_xfer, last_grade, div_ge, scan_first, scan_last;
	logic                           stable, sel_keep, out_free, emit_last, batch_done;
	logic [atrs_pkg::SUM_W-1:0]     sum_next;
	logic [5:0]                     div_t, div_diff;
	logic [atrs_pkg::MEAN_W-1:0]    mean_sat;
	logic [5:0]                     n_next;

	always_comb begin
		if (course_count_q == 5'd0) begin
			cc_eff = 5'd1;
		end else if (course_count_q > 5'(atrs_pkg::MAX_COURSES)) begin
			cc_eff = 5'(atrs_pkg::MAX_COURSES);
		end else begin
			cc_eff = course_count_q;
		end
		if (student_count_q == 6'd0) begin
			sn_eff = 6'd1;
		end else if (student_count_q > 6'(atrs_pkg::MAX_STUDENTS)) begin
			sn_eff = 6'(atrs_pkg::MAX_STUDENTS);
		end else begin
			sn_eff = student_count_q;
		end
	end

	assign in_xfer    = in_valid && !in_stall;
	assign last_grade = ({1'b0, grade_counter_q} + 5'd1) >= cc_eff;
	assign sum_next   = grade_sum_q + atrs_pkg::SUM_W'(grade);
	assign div_t      = {rem_q, dvd_q[atrs_pkg::DVD_W-1]};
	assign div_ge     = div_t >= {1'b0, cc_eff};
	assign div_diff   = div_t - {1'b0, cc_eff};
	assign mean_sat   = (|dvd_q[atrs_pkg::DVD_W-1:atrs_pkg::MEAN_W]) ?
		{atrs_pkg::MEAN_W{1'b1}} : dvd_q[atrs_pkg::MEAN_W-1:0];
	assign n_next     = {1'b0, student_counter_q} + 6'd1;
	assign batch_done = n_next >= sn_eff;
	assign scan_first = rd_addr_s1 == i_q;
	assign scan_last  = {1'b0, rd_addr_s1} == (n_q - 6'd1);
	assign stable     = sort_method_q != atrs_pkg::METHOD_SELECTION;
	assign sel_keep   = !stable && (entry_i_q.mean == best_q.mean);
	assign out_free   = !out_valid_q || !out_stall;
	assign emit_last  = {1'b0, i_q} == (n_q - 6'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			atrs_pkg::ST_LOAD: begin
				if (in_xfer && last_grade) state_d = atrs_pkg::ST_DIV;
			end
			atrs_pkg::ST_DIV: begin
				if (div_cnt_q == atrs_pkg::DIV_CNT_W'(atrs_pkg::DVD_W - 1)) begin
					state_d = atrs_pkg::ST_STORE;
				end
			end
			atrs_pkg::ST_STORE: begin
				state_d = batch_done ? atrs_pkg::ST_SCAN_START : atrs_pkg::ST_LOAD;
			end
			atrs_pkg::ST_SCAN_START: state_d = atrs_pkg::ST_SCAN;
			atrs_pkg::ST_SCAN: begin
				if (scan_last) state_d = atrs_pkg::ST_DECIDE;
			end
			atrs_pkg::ST_DECIDE: begin
				if (stable) begin
					state_d = (best_addr_q == i_q) ? atrs_pkg::ST_EMIT : atrs_pkg::ST_SH_RD;
				end else begin
					state_d = sel_keep ? atrs_pkg::ST_EMIT : atrs_pkg::ST_PLACE;
				end
			end
			atrs_pkg::ST_SH_RD: state_d = atrs_pkg::ST_SH_WR;
			atrs_pkg::ST_SH_WR: begin
				state_d = (k_q == i_q) ? atrs_pkg::ST_PLACE : atrs_pkg::ST_SH_RD;
			end
			atrs_pkg::ST_PLACE: state_d = atrs_pkg::ST_EMIT;
			atrs_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = emit_last ? atrs_pkg::ST_LOAD : atrs_pkg::ST_SCAN_START;
				end
			end
			default: state_d = atrs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall  = state_q != atrs_pkg::ST_LOAD;
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = best_q;
		rd_addr   = i_q;
		case (state_q)
			atrs_pkg::ST_STORE: begin
				mem_we    = 1'b1;
				mem_waddr = student_counter_q;
				mem_wdata = '{idx: student_counter_q, mean: mean_sat};
			end
			atrs_pkg::ST_SCAN: rd_addr = rd_addr_s1 + 1'b1;
			atrs_pkg::ST_DECIDE: begin
				if (!stable && !sel_keep) begin
					mem_we    = 1'b1;
					mem_waddr = best_addr_q;
					mem_wdata = entry_i_q;
				end
			end
			atrs_pkg::ST_SH_RD: rd_addr = k_q;
			atrs_pkg::ST_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_q + 1'b1;
				mem_wdata = rd_data_s1;
			end
			atrs_pkg::ST_PLACE: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		rd_data_s1 <= mem_q[rd_addr];
		rd_addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			course_count_q  <= 5'd1;
			student_count_q <= 6'd1;
			sort_method_q   <= atrs_pkg::METHOD_BUBBLE;
		end else if (cfg_we) begin
			case (cfg_index)
				atrs_pkg::REG_COURSE_COUNT:  course_count_q  <= cfg_data[4:0];
				atrs_pkg::REG_STUDENT_COUNT: student_count_q <= cfg_data;
				atrs_pkg::REG_SORT_METHOD:   sort_method_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= atrs_pkg::ST_LOAD;
			grade_sum_q       <= '0;
			grade_counter_q   <= '0;
			student_counter_q <= '0;
			div_cnt_q         <= '0;
			n_q               <= 6'd1;
			i_q               <= '0;
			k_q               <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == atrs_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				atrs_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (last_grade) begin
							grade_sum_q     <= '0;
							grade_counter_q <= '0;
							div_cnt_q       <= '0;
						end else begin
							grade_sum_q     <= sum_next;
							grade_counter_q <= grade_counter_q + 1'b1;
						end
					end
				end
				atrs_pkg::ST_DIV: div_cnt_q <= div_cnt_q + 1'b1;
				atrs_pkg::ST_STORE: begin
					if (batch_done) begin
						n_q               <= n_next;
						student_counter_q <= '0;
						i_q               <= '0;
					end else begin
						student_counter_q <= n_next[atrs_pkg::IDX_W-1:0];
					end
				end
				atrs_pkg::ST_DECIDE: k_q <= best_addr_q - 1'b1;
				atrs_pkg::ST_SH_WR:  k_q <= k_q - 1'b1;
				atrs_pkg::ST_EMIT: begin
					if (out_free) begin
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == atrs_pkg::ST_LOAD && in_xfer && last_grade) begin
			dvd_q <= {sum_next, {atrs_pkg::FRAC_W{1'b0}}};
			rem_q <= '0;
		end else if (state_q == atrs_pkg::ST_DIV) begin
			dvd_q <= {dvd_q[atrs_pkg::DVD_W-2:0], div_ge};
			rem_q <= div_ge ? div_diff[4:0] : div_t[4:0];
		end
		if (state_q == atrs_pkg::ST_SCAN) begin
			if (scan_first) begin
				entry_i_q   <= rd_data_s1;
				best_q      <= rd_data_s1;
				best_addr_q <= rd_addr_s1;
			end else if (best_q.mean < rd_data_s1.mean) begin
				best_q      <= rd_data_s1;
				best_addr_q <= rd_addr_s1;
			end
		end
		if (state_q == atrs_pkg::ST_DECIDE) begin
			emit_q <= sel_keep ? entry_i_q : best_q;
		end
		if (state_q == atrs_pkg::ST_EMIT && out_free) begin
			rank_q    <= i_q;
			student_q <= emit_q.idx;
			mean_q    <= emit_q.mean;
			last_q    <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign rank      = rank_q;
	assign student   = student_q;
	assign mean      = mean_q;
	assign last      = last_q;

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == atrs_pkg::ST_DIV |-> div_cnt_q < atrs_pkg::DIV_CNT_W'(atrs_pkg::DVD_W))
		else $error("divider ran past its step count");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == atrs_pkg::ST_SCAN || state_q == atrs_pkg::ST_EMIT) |->
		({1'b0, i_q} < n_q))
		else $error("rank position beyond batch size");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == atrs_pkg::ST_EMIT && out_free && emit_last) |=>
		(state_q == atrs_pkg::ST_LOAD && out_valid_q && last_q))
		else $error("final result did not end the batch");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == atrs_pkg::ST_SH_RD |-> (k_q >= i_q && k_q < best_addr_q))
		else $error("shift pointer outside the moved range");

endmodule
